### hdl/sblr_pkg.sv
package sblr_pkg;

	localparam int CFG_INDEX_BITS = 4;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_BASE = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_PITCH  = 4'd1;

	localparam logic [31:0] FRAME_BASE_RESET = 32'h1000_0000;
	localparam logic [11:0] ROW_PITCH_RESET  = 12'd720;

	// action codes
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// color code that draws nothing and drops the line
	localparam logic [3:0] COLOR_NONE = 4'd0;

	typedef struct packed {
		logic               action;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic signed [15:0] begin_x;
		logic signed [15:0] begin_y;
		logic [3:0]         color;
	} req_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [31:0]        pixel_address;
		logic [15:0]        pixel_value;
		logic               last;
	} pix_t;

	typedef struct packed {
		logic [CFG_INDEX_BITS-1:0] index;
		logic [31:0]               value;
	} cfg_t;

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_load_t;

	// RGB565 palette
	function automatic logic [15:0] color_word(input logic [2:0] code);
		logic [15:0] w;
		case (code)
			3'd0: w = 16'h0000;
			3'd1: w = 16'h001f;
			3'd2: w = 16'h07e0;
			3'd3: w = 16'h07ff;
			3'd4: w = 16'hf800;
			3'd5: w = 16'hf81f;
			3'd6: w = 16'hffe0;
			3'd7: w = 16'hffff;
			default: w = 16'h0000;
		endcase
		return w;
	endfunction

endpackage

### hdl/sblr_chan_if.sv
interface sblr_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hdl/sblr_prep.sv
module sblr_prep
	import sblr_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stage_load_t                  load,
	input  logic                         req_valid,
	input  req_t                         req_data,
	output logic                         valid_s1,
	output logic                         valid_s2,
	output logic                         action_s2,
	output logic [3:0]                   color_s2,
	output logic signed [COORD_BITS-1:0] x1_s2,
	output logic signed [COORD_BITS-1:0] y1_s2,
	output logic signed [COORD_BITS-1:0] x2_s2,
	output logic signed [COORD_BITS-1:0] y2_s2,
	output logic signed [COORD_BITS:0]   dx_s2,
	output logic signed [COORD_BITS:0]   dy_s2
);

	req_t req_s1;
	logic signed [COORD_BITS-1:0] x1, y1, x2, y2;

	// v*45/64, floored, then sized to the coordinate width
	function automatic logic signed [COORD_BITS-1:0] scale(input logic signed [15:0] v);
		logic signed [21:0] ve;
		logic signed [21:0] p;
		logic signed [21:0] q;
		logic signed [31:0] q32;
		ve  = {{6{v[15]}}, v};
		p   = (ve <<< 5) + (ve <<< 3) + (ve <<< 2) + ve;
		q   = p >>> 6;
		q32 = {{10{q[21]}}, q};
		return q32[COORD_BITS-1:0];
	endfunction

	always_comb begin
		x2 = scale(req_s1.end_x);
		y2 = scale(req_s1.end_y);
		x1 = scale(req_s1.begin_x);
		y1 = scale(req_s1.begin_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load.s1) begin
				valid_s1 <= req_valid;
			end
			if (load.s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load.s1) begin
			req_s1 <= req_data;
		end
		if (load.s2) begin
			action_s2 <= req_s1.action;
			color_s2  <= req_s1.color;
			x1_s2     <= x1;
			y1_s2     <= y1;
			x2_s2     <= x2;
			y2_s2     <= y2;
			dx_s2     <= {x2[COORD_BITS-1], x2} - {x1[COORD_BITS-1], x1};
			dy_s2     <= {y2[COORD_BITS-1], y2} - {y1[COORD_BITS-1], y1};
		end
	end

endmodule

### hdl/sblr_walk.sv
module sblr_walk
	import sblr_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stage_load_t                  load,
	input  logic                         valid_s2,
	input  logic                         action_s2,
	input  logic [3:0]                   color_s2,
	input  logic signed [COORD_BITS-1:0] x1_s2,
	input  logic signed [COORD_BITS-1:0] y1_s2,
	input  logic signed [COORD_BITS-1:0] x2_s2,
	input  logic signed [COORD_BITS-1:0] y2_s2,
	input  logic signed [COORD_BITS:0]   dx_s2,
	input  logic signed [COORD_BITS:0]   dy_s2,
	output logic                         valid_s3,
	output logic signed [COORD_BITS-1:0] x_s3,
	output logic signed [COORD_BITS-1:0] y_s3,
	output logic [15:0]                  color_s3,
	output logic                         last_s3,
	output logic                         line_active
);

	localparam int EB = COORD_BITS + 4;
	localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1);

	// walker state
	logic signed [COORD_BITS-1:0] walk_x_q, walk_y_q, limit_q;
	logic signed [EB-1:0]         err_q, keep_inc_q, step_inc_q;
	logic                         y_major_q, minor_inc_q, active_q;
	logic [15:0]                  color_q;

	// start path
	logic                         dx_neg, dy_neg, dx_pos, dy_pos;
	logic [COORD_BITS:0]          adx, ady, a_min, a_maj;
	logic                         y_major, minor_inc, fwd, start_last;
	logic signed [EB-1:0]         keep_inc, step_inc, err_init;
	logic signed [COORD_BITS-1:0] sx, sy, lim;
	logic [15:0]                  new_color;

	// advance path
	logic                         step_minor, adv_last;
	logic signed [EB-1:0]         err_next;
	logic signed [COORD_BITS-1:0] minor_x, minor_y, nx, ny;

	always_comb begin
		dx_neg    = dx_s2[COORD_BITS];
		dy_neg    = dy_s2[COORD_BITS];
		dx_pos    = !dx_neg && (dx_s2 != '0);
		dy_pos    = !dy_neg && (dy_s2 != '0);
		adx       = dx_neg ? $unsigned(-dx_s2) : $unsigned(dx_s2);
		ady       = dy_neg ? $unsigned(-dy_s2) : $unsigned(dy_s2);
		y_major   = ady > adx;
		minor_inc = (dx_neg && dy_neg) || (dx_pos && dy_pos);
		a_min     = y_major ? adx : ady;
		a_maj     = y_major ? ady : adx;
		keep_inc  = {2'b00, a_min, 1'b0};
		step_inc  = keep_inc - {2'b00, a_maj, 1'b0};
		err_init  = keep_inc - {3'b000, a_maj};
		fwd       = y_major ? !dy_neg : !dx_neg;
		sx        = fwd ? x1_s2 : x2_s2;
		sy        = fwd ? y1_s2 : y2_s2;
		if (y_major) begin
			lim = fwd ? y2_s2 : y1_s2;
		end else begin
			lim = fwd ? x2_s2 : x1_s2;
		end
		start_last = y_major ? (sy >= lim) : (sx >= lim);
		// codes 8 and up keep the current line color
		new_color  = color_s2[3] ? color_q : color_word(color_s2[2:0]);

		// x-major steps the minor axis on err >= 0, y-major only on err > 0
		if (y_major_q) begin
			step_minor = !err_q[EB-1] && (err_q != '0);
		end else begin
			step_minor = !err_q[EB-1];
		end
		err_next = err_q + (step_minor ? step_inc_q : keep_inc_q);
		minor_x  = minor_inc_q ? walk_x_q + ONE : walk_x_q - ONE;
		minor_y  = minor_inc_q ? walk_y_q + ONE : walk_y_q - ONE;
		if (y_major_q) begin
			ny = walk_y_q + ONE;
			nx = step_minor ? minor_x : walk_x_q;
		end else begin
			nx = walk_x_q + ONE;
			ny = step_minor ? minor_y : walk_y_q;
		end
		adv_last = y_major_q ? (ny >= limit_q) : (nx >= limit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			walk_x_q    <= '0;
			walk_y_q    <= '0;
			limit_q     <= '0;
			err_q       <= '0;
			keep_inc_q  <= '0;
			step_inc_q  <= '0;
			y_major_q   <= 1'b0;
			minor_inc_q <= 1'b0;
			active_q    <= 1'b0;
			color_q     <= '0;
		end else if (load.s3) begin
			valid_s3 <= 1'b0;
			if (valid_s2) begin
				case (action_s2)
					ACT_START: begin
						color_q  <= new_color;
						active_q <= 1'b0;
						if (color_s2 != COLOR_NONE) begin
							walk_x_q    <= sx;
							walk_y_q    <= sy;
							limit_q     <= lim;
							err_q       <= err_init;
							keep_inc_q  <= keep_inc;
							step_inc_q  <= step_inc;
							y_major_q   <= y_major;
							minor_inc_q <= minor_inc;
							active_q    <= !start_last;
							valid_s3    <= 1'b1;
						end
					end
					ACT_ADVANCE: begin
						if (active_q) begin
							walk_x_q <= nx;
							walk_y_q <= ny;
							err_q    <= err_next;
							active_q <= !adv_last;
							valid_s3 <= 1'b1;
						end
					end
					default: begin
						valid_s3 <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load.s3) begin
			if (action_s2 == ACT_START) begin
				x_s3     <= sx;
				y_s3     <= sy;
				color_s3 <= new_color;
				last_s3  <= start_last;
			end else begin
				x_s3     <= nx;
				y_s3     <= ny;
				color_s3 <= color_q;
				last_s3  <= adv_last;
			end
		end
	end

	assign line_active = active_q;

endmodule

### hdl/sblr_addr.sv
module sblr_addr
	import sblr_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stage_load_t                  load,
	input  logic                         valid_s3,
	input  logic signed [COORD_BITS-1:0] x_s3,
	input  logic signed [COORD_BITS-1:0] y_s3,
	input  logic [15:0]                  color_s3,
	input  logic                         last_s3,
	input  logic [31:0]                  frame_base,
	input  logic [11:0]                  row_pitch,
	output logic                         valid_s4,
	output pix_t                         pix_s4
);

	logic signed [31:0] x32, y32;
	logic [31:0]        pitch32, row_off, addr;

	always_comb begin
		x32     = 32'(x_s3);
		y32     = 32'(y_s3);
		pitch32 = {20'b0, row_pitch};
		row_off = $unsigned(y32) * pitch32;
		// shifting left clears bit 0 of the offset before the frame base is ORed in
		addr    = ((row_off + $unsigned(x32)) << 1) | frame_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (load.s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load.s4) begin
			pix_s4.pixel_x       <= x32[15:0];
			pix_s4.pixel_y       <= y32[15:0];
			pix_s4.pixel_address <= addr;
			pix_s4.pixel_value   <= color_s3;
			pix_s4.last          <= last_s3;
		end
	end

endmodule

### hdl/scaled_bresenham_line_rasterizer.sv
// Line rasterizer for a 16-bit RGB565 frame buffer. A start word scales both
// endpoints by 45/64 (floor), picks the color and emits the first pixel unless
// the color code is 0; each advance word on an active line emits the next pixel
// along its major axis, with last set on the final one. Throughput is one word
// per clock while pix.ready is not holding the pixel register: the Bresenham
// step (error add and compare feeding the walker registers) is combinational.
// A word passes four registers: input register, scaling and deltas, the
// walker, then the row*pitch multiply and address add. Stages with no pixel
// collapse, so words keep flowing while a finished pixel waits. Configuration
// is written through cfg, index 0 frame base and index 1 row pitch, and is
// taken in any cycle.
module scaled_bresenham_line_rasterizer
	import sblr_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	sblr_chan_if.sink        req,
	sblr_chan_if.source      pix,
	sblr_chan_if.sink        cfg
);

	logic [31:0] frame_base_q;
	logic [11:0] row_pitch_q;

	stage_load_t load;
	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        action_s2;
	logic [3:0]  color_s2;
	logic signed [COORD_BITS-1:0] x1_s2, y1_s2, x2_s2, y2_s2;
	logic signed [COORD_BITS:0]   dx_s2, dy_s2;
	logic signed [COORD_BITS-1:0] x_s3, y_s3;
	logic [15:0] color_s3;
	logic        last_s3;
	logic        line_active;
	pix_t        pix_s4;
	cfg_t        cfg_word;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		load.s4 = !valid_s4 || pix.ready;
		load.s3 = !valid_s3 || load.s4;
		load.s2 = !valid_s2 || load.s3;
		load.s1 = !valid_s1 || load.s2;
	end

	assign req.ready = load.s1;
	assign pix.valid = valid_s4;
	assign pix.data  = pix_s4;
	assign cfg.ready = 1'b1;
	assign cfg_word  = cfg.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= FRAME_BASE_RESET;
			row_pitch_q  <= ROW_PITCH_RESET;
		end else if (cfg.valid) begin
			case (cfg_word.index)
				CFG_FRAME_BASE: frame_base_q <= cfg_word.value;
				CFG_ROW_PITCH:  row_pitch_q  <= cfg_word.value[11:0];
				default: begin
					frame_base_q <= frame_base_q;
				end
			endcase
		end
	end

	sblr_prep #(.COORD_BITS(COORD_BITS)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.req_valid (req.valid),
		.req_data  (req.data),
		.valid_s1  (valid_s1),
		.valid_s2  (valid_s2),
		.action_s2 (action_s2),
		.color_s2  (color_s2),
		.x1_s2     (x1_s2),
		.y1_s2     (y1_s2),
		.x2_s2     (x2_s2),
		.y2_s2     (y2_s2),
		.dx_s2     (dx_s2),
		.dy_s2     (dy_s2)
	);

	sblr_walk #(.COORD_BITS(COORD_BITS)) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.valid_s2    (valid_s2),
		.action_s2   (action_s2),
		.color_s2    (color_s2),
		.x1_s2       (x1_s2),
		.y1_s2       (y1_s2),
		.x2_s2       (x2_s2),
		.y2_s2       (y2_s2),
		.dx_s2       (dx_s2),
		.dy_s2       (dy_s2),
		.valid_s3    (valid_s3),
		.x_s3        (x_s3),
		.y_s3        (y_s3),
		.color_s3    (color_s3),
		.last_s3     (last_s3),
		.line_active (line_active)
	);

	sblr_addr #(.COORD_BITS(COORD_BITS)) u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.valid_s3   (valid_s3),
		.x_s3       (x_s3),
		.y_s3       (y_s3),
		.color_s3   (color_s3),
		.last_s3    (last_s3),
		.frame_base (frame_base_q),
		.row_pitch  (row_pitch_q),
		.valid_s4   (valid_s4),
		.pix_s4     (pix_s4)
	);

`ifndef SYNTH
	// an empty pixel register must never hold off the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!pix.valid |-> req.ready)
		else $error("input stalled with empty pixel register");

	// a waiting walker pixel matches the line state it left behind
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (line_active != last_s3))
		else $error("line active flag disagrees with last pixel");
`endif

endmodule
